// ----- rtl/core/laf_pkg.sv -----
`timescale 1ns / 1ps

package laf_pkg;

    localparam int LINE_LEN_DEF   = 64;
    localparam int FIFO_DEPTH_DEF = 8;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Input item kinds.
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_POP  = 1'b1;

    typedef enum logic [1:0] {
        REPLY_BYTE  = 2'd0,
        REPLY_EMPTY = 2'd1,
        REPLY_DROP  = 2'd2
    } t_reply_kind;

    typedef struct packed {
        logic byte_acc;   // received byte beat accepted
        logic pop_start;  // pop accepted with a line queued
        logic len_rd;     // read the length of the popped line
        logic first_rd;   // load the length, read the first byte
        logic next_rd;    // shown byte taken, read the next one
        logic show;       // a line byte is on the output
    } t_ctl_cmd;

    typedef struct packed {
        logic drop;       // the byte on the input finishes a line that finds the FIFO full
        logic held_zero;  // no line queued
        logic idx_last;   // the byte on the output is the last of its line
    } t_dp_status;

endpackage

// ----- rtl/core/laf_ram.sv -----
`timescale 1ns / 1ps

module laf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/laf_dpath.sv -----
`timescale 1ns / 1ps

module laf_dpath import laf_pkg::*; #(
    parameter int LINE_LEN   = LINE_LEN_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_in_byte,
    input  t_ctl_cmd   i_cmd,
    output t_dp_status o_status,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_lines_held
);

    // One slot more than the queue depth, so the line under assembly always
    // has a free slot of its own and is never copied.
    localparam int NS = FIFO_DEPTH + 1;
    localparam int SW = $clog2(NS);
    localparam int HW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = $clog2(LINE_LEN);
    localparam int AW = $clog2(NS * LINE_LEN);

    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_after_cr, n_after_cr;
    logic [SW-1:0] r_wr_slot, n_wr_slot;
    logic [SW-1:0] r_rd_slot, n_rd_slot;
    logic [SW-1:0] r_pop_slot, n_pop_slot;
    logic [HW-1:0] r_held, n_held;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_idx, n_idx;

    logic          w_is_cr, w_is_lf, w_is_other;
    logic          w_finish, w_store, w_full;
    logic          w_line_we, w_line_re, w_len_we;
    logic [AW-1:0] w_line_waddr, w_line_raddr;
    logic [LW-1:0] w_rd_idx;
    logic [7:0]    w_line_rdata;
    logic [LW-1:0] w_len_rdata;

    assign w_is_cr    = (i_in_byte == CHAR_CR);
    assign w_is_lf    = (i_in_byte == CHAR_LF);
    assign w_is_other = !w_is_cr && !w_is_lf;
    assign w_full     = (r_held == HW'(FIFO_DEPTH));

    assign w_finish = (w_is_cr && (r_cnt != '0))
                   || (w_is_lf && !r_after_cr && (r_cnt != '0))
                   || (w_is_other && (r_cnt == LW'(LINE_LEN - 1)));
    assign w_store  = w_is_other && (r_cnt != LW'(LINE_LEN - 1));

    assign w_line_we    = i_cmd.byte_acc && w_store;
    assign w_len_we     = i_cmd.byte_acc && w_finish && !w_full;
    assign w_line_waddr = AW'(r_wr_slot) * AW'(LINE_LEN) + AW'(r_cnt);

    assign w_line_re    = i_cmd.first_rd || i_cmd.next_rd;
    assign w_rd_idx     = i_cmd.first_rd ? '0 : r_idx + 1'b1;
    assign w_line_raddr = AW'(r_pop_slot) * AW'(LINE_LEN) + AW'(w_rd_idx);

    always_comb begin
        n_cnt      = r_cnt;
        n_after_cr = r_after_cr;
        n_wr_slot  = r_wr_slot;
        n_rd_slot  = r_rd_slot;
        n_pop_slot = r_pop_slot;
        n_held     = r_held;
        n_len      = r_len;
        n_idx      = r_idx;
        if (i_cmd.byte_acc) begin
            n_after_cr = w_is_cr;
            if (w_store) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (w_finish) begin
                n_cnt = '0;
                if (!w_full) begin
                    n_wr_slot = (r_wr_slot == SW'(NS - 1)) ? '0 : r_wr_slot + 1'b1;
                    n_held    = r_held + 1'b1;
                end
            end
        end
        if (i_cmd.pop_start) begin
            n_pop_slot = r_rd_slot;
            n_rd_slot  = (r_rd_slot == SW'(NS - 1)) ? '0 : r_rd_slot + 1'b1;
            n_held     = r_held - 1'b1;
        end
        if (i_cmd.first_rd) begin
            n_len = w_len_rdata;
            n_idx = '0;
        end
        if (i_cmd.next_rd) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_after_cr <= 1'b0;
            r_wr_slot  <= '0;
            r_rd_slot  <= '0;
            r_held     <= '0;
        end else begin
            r_cnt      <= n_cnt;
            r_after_cr <= n_after_cr;
            r_wr_slot  <= n_wr_slot;
            r_rd_slot  <= n_rd_slot;
            r_held     <= n_held;
        end
        r_pop_slot <= n_pop_slot;
        r_len      <= n_len;
        r_idx      <= n_idx;
    end

    laf_ram #(
        .WIDTH (8),
        .DEPTH (NS * LINE_LEN)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (w_line_waddr),
        .i_wdata (i_in_byte),
        .i_re    (w_line_re),
        .i_raddr (w_line_raddr),
        .o_rdata (w_line_rdata)
    );

    laf_ram #(
        .WIDTH (LW),
        .DEPTH (NS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (r_wr_slot),
        .i_wdata (r_cnt),
        .i_re    (i_cmd.len_rd),
        .i_raddr (r_pop_slot),
        .o_rdata (w_len_rdata)
    );

    assign o_status.drop      = w_finish && w_full;
    assign o_status.held_zero = (r_held == '0);
    assign o_status.idx_last  = (r_idx == r_len - 1'b1);

    assign o_out_byte   = i_cmd.show ? w_line_rdata : 8'h00;
    assign o_lines_held = 4'(r_held);

`ifndef ASSERT_OFF
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(FIFO_DEPTH))
        else $error("queued line count above the queue depth");

    a_ring_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wr_slot >= r_rd_slot) ? (r_wr_slot - r_rd_slot)
                                  : (r_wr_slot + SW'(NS) - r_rd_slot)) == SW'(r_held))
        else $error("slot pointers disagree with the queued line count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_start |-> (r_held != '0))
        else $error("pop started on an empty queue");

    a_pop_decrement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_start |=> (r_held == HW'($past(r_held) - 1'b1)))
        else $error("pop did not remove exactly one line");
`endif

endmodule

// ----- rtl/core/laf_ctrl.sv -----
`timescale 1ns / 1ps

module laf_ctrl import laf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_kind,
    input  logic        i_ready,
    input  t_dp_status  i_status,
    output logic        o_ready,
    output logic        o_valid,
    output t_reply_kind o_reply_kind,
    output logic        o_line_last,
    output t_ctl_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_POP_LEN,
        ST_POP_FIRST,
        ST_POP_SHOW
    } t_state;

    t_state      r_state, n_state;
    t_reply_kind r_reply_kind, n_reply_kind;
    logic        w_in_acc;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_in_acc = o_ready && i_valid;

    always_comb begin
        n_state      = r_state;
        n_reply_kind = r_reply_kind;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_kind == IN_POP) begin
                        if (i_status.held_zero) begin
                            n_state      = ST_REPLY;
                            n_reply_kind = REPLY_EMPTY;
                        end else begin
                            n_state = ST_POP_LEN;
                        end
                    end else if (i_status.drop) begin
                        n_state      = ST_REPLY;
                        n_reply_kind = REPLY_DROP;
                    end
                end
            end
            ST_REPLY: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP_LEN:   n_state = ST_POP_FIRST;
            ST_POP_FIRST: n_state = ST_POP_SHOW;
            ST_POP_SHOW: begin
                if (i_ready && i_status.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_reply_kind <= REPLY_EMPTY;
        end else begin
            r_state      <= n_state;
            r_reply_kind <= n_reply_kind;
        end
    end

    assign o_cmd.byte_acc  = w_in_acc && (i_kind == IN_BYTE);
    assign o_cmd.pop_start = w_in_acc && (i_kind == IN_POP) && !i_status.held_zero;
    assign o_cmd.len_rd    = (r_state == ST_POP_LEN);
    assign o_cmd.first_rd  = (r_state == ST_POP_FIRST);
    // The next byte is fetched in the beat where the current one is taken.
    assign o_cmd.next_rd   = (r_state == ST_POP_SHOW) && i_ready && !i_status.idx_last;
    assign o_cmd.show      = (r_state == ST_POP_SHOW);

    assign o_valid      = (r_state == ST_REPLY) || (r_state == ST_POP_SHOW);
    assign o_reply_kind = (r_state == ST_POP_SHOW) ? REPLY_BYTE : r_reply_kind;
    assign o_line_last  = (r_state == ST_REPLY)
                       || ((r_state == ST_POP_SHOW) && i_status.idx_last);

endmodule

// ----- rtl/core/line_assembler_with_line_fifo_top.sv -----
`timescale 1ns / 1ps
// Line assembler with a queue of finished lines.
// Input channel (i_valid/o_ready): i_kind 0 carries a received character in
// i_in_byte, i_kind 1 asks for the oldest queued line. CR or LF ends a line,
// LF right after CR is skipped, empty lines are not queued, and a character
// arriving when the line already holds LINE_LEN-1 bytes flushes it and is lost.
// Output channel (o_valid/i_ready): one beat per line byte on a pop, with
// o_line_last on the final byte; a single beat with o_line_last for an empty
// pop or for a line dropped because FIFO_DEPTH lines are already queued.
// o_lines_held gives the queued line count after the input that caused it.
// Rate: received characters that cause no reply are taken one per cycle.
// A drop or empty reply appears the cycle after its input beat. A pop shows
// its first byte after ST_POP_LEN (length read), then ST_POP_FIRST (byte read
// from the line memory), then one byte per cycle while i_ready stays high.
// The next input is taken the cycle after the last reply beat is taken.
// While the receiver stalls, the shown beat holds and no input is taken.
// Reset clears the queue and the partial line; no memory clearing is needed.
module line_assembler_with_line_fifo_top import laf_pkg::*; #(
    parameter int LINE_LEN   = LINE_LEN_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_reply_kind,
    output logic [7:0] o_out_byte,
    output logic       o_line_last,
    output logic [3:0] o_lines_held
);

    t_ctl_cmd    w_cmd;
    t_dp_status  w_status;
    t_reply_kind w_reply_kind;

    laf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_kind       (i_kind),
        .i_ready      (i_ready),
        .i_status     (w_status),
        .o_ready      (o_ready),
        .o_valid      (o_valid),
        .o_reply_kind (w_reply_kind),
        .o_line_last  (o_line_last),
        .o_cmd        (w_cmd)
    );

    laf_dpath #(
        .LINE_LEN   (LINE_LEN),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_byte    (i_in_byte),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_byte   (o_out_byte),
        .o_lines_held (o_lines_held)
    );

    assign o_reply_kind = w_reply_kind;

endmodule
